/* src/c6502_pkg.sv */
// package: constants, phase codes and opcode helpers for the 6502 subset core
package c6502_pkg;

  localparam logic [15:0] START_ADDRESS_RESET = 16'hC000;
  localparam logic [7:0]  STACK_POINTER_RESET = 8'hFF;
  localparam logic [7:0]  STACK_PAGE          = 8'h01;

  localparam logic [0:0] CFG_START_ADDRESS = 1'b0;
  localparam logic [0:0] CFG_STACK_POINTER = 1'b1;

  localparam logic [3:0] PH_FETCH      = 4'd0;
  localparam logic [3:0] PH_BYTE1      = 4'd1;
  localparam logic [3:0] PH_BYTE2      = 4'd2;
  localparam logic [3:0] PH_READ       = 4'd3;
  localparam logic [3:0] PH_WRITE_LAST = 4'd4;
  localparam logic [3:0] PH_JSR_HI     = 4'd5;
  localparam logic [3:0] PH_RTS_LO     = 4'd6;
  localparam logic [3:0] PH_RTS_HI     = 4'd7;

  localparam logic [7:0] OP_BRK = 8'h00, OP_CLC = 8'h18, OP_DEX = 8'hCA, OP_DEY = 8'h88;
  localparam logic [7:0] OP_INX = 8'hE8, OP_INY = 8'hC8, OP_PLA = 8'h68, OP_PHA = 8'h48;
  localparam logic [7:0] OP_RTS = 8'h60, OP_TAX = 8'hAA, OP_TAY = 8'hA8, OP_TXA = 8'h8A;
  localparam logic [7:0] OP_TYA = 8'h98, OP_ASLA = 8'h0A, OP_ROLA = 8'h2A;
  localparam logic [7:0] OP_ADCI = 8'h69, OP_ANDI = 8'h29, OP_CMPI = 8'hC9, OP_CPXI = 8'hE0;
  localparam logic [7:0] OP_CPYI = 8'hC0, OP_EORI = 8'h49, OP_LDAI = 8'hA9, OP_LDXI = 8'hA2;
  localparam logic [7:0] OP_LDYI = 8'hA0, OP_BCC = 8'h90, OP_BEQ = 8'hF0, OP_BNE = 8'hD0;
  localparam logic [7:0] OP_BCS = 8'hB0, OP_JMP = 8'h4C, OP_JSR = 8'h20;
  localparam logic [7:0] OP_ADCA = 8'h6D, OP_LDAA = 8'hAD, OP_LDXA = 8'hAE, OP_LDAX = 8'hBD;
  localparam logic [7:0] OP_ASLM = 8'h0E, OP_ROLM = 8'h2E, OP_INCM = 8'hEE;
  localparam logic [7:0] OP_STAA = 8'h8D, OP_STAX = 8'h9D, OP_STXA = 8'h8E, OP_STYA = 8'h8C;

  // flags held as n v z c
  typedef struct packed {
    logic n;
    logic v;
    logic z;
    logic c;
  } flags_t;

  // instruction length in bytes
  function automatic logic [1:0] op_length(input logic [7:0] op);
    logic [1:0] len;
    case (op) inside
      OP_BRK, OP_CLC, OP_DEX, OP_DEY, OP_INX, OP_INY, OP_PLA, OP_PHA, OP_RTS,
      OP_TAX, OP_TAY, OP_TXA, OP_TYA, OP_ASLA, OP_ROLA: len = 2'd1;
      OP_ADCI, OP_ANDI, OP_CMPI, OP_CPXI, OP_CPYI, OP_EORI, OP_LDAI, OP_LDXI,
      OP_LDYI, OP_BCC, OP_BEQ, OP_BNE, OP_BCS: len = 2'd2;
      default: len = 2'd3;
    endcase
    return len;
  endfunction

endpackage

/* src/c6502_alu.sv */
// alu: adc, compare and shift results with flag updates
module c6502_alu (
  input  logic [7:0]          a,
  input  logic [7:0]          m,
  input  c6502_pkg::flags_t   flags_in,
  input  logic [1:0]          func,
  output logic [7:0]          result,
  output c6502_pkg::flags_t   flags_out
);
  // func: 0 adc, 1 compare, 2 asl, 3 rol
  logic [8:0] sum;
  logic [8:0] diff;

  always_comb begin
    sum = {1'b0, a} + {1'b0, m} + {8'd0, flags_in.c};
    diff = {1'b0, a} - {1'b0, m};
    flags_out = flags_in;
    result = a;
    case (func)
      2'd0: begin
        result = sum[7:0];
        flags_out.c = sum[8];
        flags_out.v = ~(a[7] ^ m[7]) & (a[7] ^ sum[7]);
      end
      2'd1: begin
        result = a;
        flags_out.c = ~diff[8];
        flags_out.n = diff[7];
        flags_out.z = (diff[7:0] == 8'd0);
      end
      2'd2: begin
        result = {a[6:0], 1'b0};
        flags_out.c = a[7];
      end
      default: begin
        result = {a[6:0], flags_in.c};
        flags_out.c = a[7];
      end
    endcase
    if (func != 2'd1) begin
      flags_out.n = result[7];
      flags_out.z = (result == 8'd0);
    end
  end
endmodule

/* src/cpu_6502_subset_core.sv */
// top level: 6502 subset core, one bus access per item
// Each input item completes the pending bus access and carries its read data
// (ignored after a write); each result item names the next access. After reset
// the pending access is the opcode fetch at start_address, so the first item
// is that opcode. The sequencer updates the registers and forms the next
// access in a single pass, and a result register with a one-entry skid lets
// one more item enter while a result waits.
// Instructions take 1 to 3 fetch items plus up to two data or stack items.
// BRK halts: from then on every result reads the program counter with halted
// set. Configuration writes load the program counter or stack pointer at once.
module cpu_6502_subset_core (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  read_data,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [15:0] bus_address,
  output logic        bus_write,
  output logic [7:0]  write_data,
  output logic        is_opcode_fetch,
  output logic        halted,
  input  logic        cfg_write,
  input  logic [0:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  data;
    logic        fetch;
    logic        halt;
  } result_t;

  // architectural state
  logic [15:0] pc, pc_next;
  logic [7:0]  acc, acc_next, xr, xr_next, yr, yr_next, sp, sp_next, latch, latch_next;
  c6502_pkg::flags_t flags, flags_next;
  logic [23:0] ibytes, ibytes_next;
  logic [3:0]  phase, phase_next;
  logic        halt, halt_next;
  result_t     res;

  // output register plus skid entry
  result_t     out_reg, skid;
  logic        skid_valid;
  logic        accept;

  assign in_stall = skid_valid;
  assign accept = in_valid & ~in_stall;

  // alu hookup
  logic [7:0] alu_a, alu_m, alu_res;
  logic [1:0] alu_func;
  c6502_pkg::flags_t alu_flags;

  c6502_alu u_alu (
    .a(alu_a), .m(alu_m), .flags_in(flags), .func(alu_func),
    .result(alu_res), .flags_out(alu_flags)
  );

  logic [7:0]  op, b1, d;
  logic [15:0] target, eff, pc_inc, ret, br;
  logic [7:0]  m;

  function automatic c6502_pkg::flags_t nz(input c6502_pkg::flags_t f, input logic [7:0] v);
    c6502_pkg::flags_t r;
    r = f;
    r.n = v[7];
    r.z = (v == 8'd0);
    return r;
  endfunction

  always_comb begin
    d = read_data;
    pc_next = pc; acc_next = acc; xr_next = xr; yr_next = yr; sp_next = sp;
    latch_next = latch; flags_next = flags; ibytes_next = ibytes;
    phase_next = phase; halt_next = halt;
    pc_inc = pc + 16'd1;
    alu_a = acc; alu_m = d; alu_func = 2'd0;
    m = 8'd0;
    res = '{addr: pc, wr: 1'b0, data: 8'd0, fetch: 1'b0, halt: halt};

    // instruction bytes as seen by execute, after this item's byte is merged
    op = ibytes[7:0];
    b1 = ibytes[15:8];
    target = ibytes[23:8];
    case (phase)
      c6502_pkg::PH_FETCH: op = d;
      c6502_pkg::PH_BYTE1: begin b1 = d; target = {8'd0, d}; end
      c6502_pkg::PH_BYTE2: target = {d, ibytes[15:8]};
      default: ;
    endcase
    eff = target + ((op == c6502_pkg::OP_LDAX || op == c6502_pkg::OP_STAX) ?
                    {8'd0, xr} : 16'd0);
    ret = pc_inc - 16'd1;
    br = pc_inc + {{8{b1[7]}}, b1};

    if (!halt) begin
      // fetch phases plus execute
      if (phase == c6502_pkg::PH_FETCH || phase == c6502_pkg::PH_BYTE1 ||
          phase == c6502_pkg::PH_BYTE2) begin
        pc_next = pc_inc;
        ibytes_next = {target[15:8], b1, op};
        if (phase == c6502_pkg::PH_FETCH) ibytes_next = {16'd0, d};
        if (phase == c6502_pkg::PH_FETCH && c6502_pkg::op_length(d) > 2'd1) begin
          phase_next = c6502_pkg::PH_BYTE1;
          res.addr = pc_inc;
        end else if (phase == c6502_pkg::PH_BYTE1 &&
                     c6502_pkg::op_length(op) > 2'd2) begin
          phase_next = c6502_pkg::PH_BYTE2;
          res.addr = pc_inc;
        end else begin
          // execute; default outcome is the next opcode fetch
          phase_next = c6502_pkg::PH_FETCH;
          res.addr = pc_inc;
          res.fetch = 1'b1;
          case (op)
            c6502_pkg::OP_BRK: begin
              halt_next = 1'b1; res.fetch = 1'b0; res.halt = 1'b1;
            end
            c6502_pkg::OP_CLC: flags_next.c = 1'b0;
            c6502_pkg::OP_DEX: begin xr_next = xr - 8'd1; flags_next = nz(flags, xr_next); end
            c6502_pkg::OP_DEY: begin yr_next = yr - 8'd1; flags_next = nz(flags, yr_next); end
            c6502_pkg::OP_INX: begin xr_next = xr + 8'd1; flags_next = nz(flags, xr_next); end
            c6502_pkg::OP_INY: begin yr_next = yr + 8'd1; flags_next = nz(flags, yr_next); end
            c6502_pkg::OP_TAX: begin xr_next = acc; flags_next = nz(flags, acc); end
            c6502_pkg::OP_TAY: begin yr_next = acc; flags_next = nz(flags, acc); end
            c6502_pkg::OP_TXA: begin acc_next = xr; flags_next = nz(flags, xr); end
            c6502_pkg::OP_TYA: begin acc_next = yr; flags_next = nz(flags, yr); end
            c6502_pkg::OP_ASLA, c6502_pkg::OP_ROLA: begin
              alu_func = (op == c6502_pkg::OP_ASLA) ? 2'd2 : 2'd3;
              acc_next = alu_res; flags_next = alu_flags;
            end
            c6502_pkg::OP_ADCI: begin
              alu_m = b1; acc_next = alu_res; flags_next = alu_flags;
            end
            c6502_pkg::OP_ANDI: begin acc_next = acc & b1; flags_next = nz(flags, acc_next); end
            c6502_pkg::OP_EORI: begin acc_next = acc ^ b1; flags_next = nz(flags, acc_next); end
            c6502_pkg::OP_CMPI, c6502_pkg::OP_CPXI, c6502_pkg::OP_CPYI: begin
              alu_func = 2'd1; alu_m = b1;
              alu_a = (op == c6502_pkg::OP_CMPI) ? acc :
                      (op == c6502_pkg::OP_CPXI) ? xr : yr;
              flags_next = alu_flags;
            end
            c6502_pkg::OP_LDAI: begin acc_next = b1; flags_next = nz(flags, b1); end
            c6502_pkg::OP_LDXI: begin xr_next = b1; flags_next = nz(flags, b1); end
            c6502_pkg::OP_LDYI: begin yr_next = b1; flags_next = nz(flags, b1); end
            c6502_pkg::OP_BCC, c6502_pkg::OP_BCS, c6502_pkg::OP_BEQ, c6502_pkg::OP_BNE: begin
              if ((op == c6502_pkg::OP_BCC && !flags.c) || (op == c6502_pkg::OP_BCS && flags.c) ||
                  (op == c6502_pkg::OP_BEQ && flags.z) || (op == c6502_pkg::OP_BNE && !flags.z))
              begin
                pc_next = br; res.addr = br;
              end
            end
            c6502_pkg::OP_JMP: begin pc_next = target; res.addr = target; end
            c6502_pkg::OP_ADCA, c6502_pkg::OP_LDAA, c6502_pkg::OP_LDXA, c6502_pkg::OP_LDAX,
            c6502_pkg::OP_ASLM, c6502_pkg::OP_ROLM, c6502_pkg::OP_INCM: begin
              phase_next = c6502_pkg::PH_READ; res.addr = eff; res.fetch = 1'b0;
            end
            c6502_pkg::OP_STAA, c6502_pkg::OP_STAX, c6502_pkg::OP_STXA,
            c6502_pkg::OP_STYA: begin
              phase_next = c6502_pkg::PH_WRITE_LAST; res.addr = eff; res.fetch = 1'b0;
              res.wr = 1'b1;
              res.data = (op == c6502_pkg::OP_STXA) ? xr :
                         (op == c6502_pkg::OP_STYA) ? yr : acc;
            end
            c6502_pkg::OP_PHA: begin
              phase_next = c6502_pkg::PH_WRITE_LAST; res.addr = {c6502_pkg::STACK_PAGE, sp};
              res.fetch = 1'b0; res.wr = 1'b1; res.data = acc; sp_next = sp - 8'd1;
            end
            c6502_pkg::OP_PLA: begin
              sp_next = sp + 8'd1; phase_next = c6502_pkg::PH_READ;
              res.addr = {c6502_pkg::STACK_PAGE, sp_next}; res.fetch = 1'b0;
            end
            c6502_pkg::OP_JSR: begin
              latch_next = ret[7:0];
              res.addr = {c6502_pkg::STACK_PAGE, sp}; res.wr = 1'b1; res.data = ret[15:8];
              res.fetch = 1'b0; sp_next = sp - 8'd1; pc_next = target;
              phase_next = c6502_pkg::PH_JSR_HI;
            end
            c6502_pkg::OP_RTS: begin
              sp_next = sp + 8'd1; phase_next = c6502_pkg::PH_RTS_LO;
              res.addr = {c6502_pkg::STACK_PAGE, sp_next}; res.fetch = 1'b0;
            end
            default: ;
          endcase
        end
      end else begin
        phase_next = c6502_pkg::PH_FETCH;
        res.addr = pc;
        res.fetch = 1'b1;
        case (phase)
          c6502_pkg::PH_READ: begin
            eff = ibytes[23:8] + ((op == c6502_pkg::OP_LDAX) ? {8'd0, xr} : 16'd0);
            case (op)
              c6502_pkg::OP_ADCA: begin acc_next = alu_res; flags_next = alu_flags; end
              c6502_pkg::OP_LDAA, c6502_pkg::OP_LDAX, c6502_pkg::OP_PLA: begin
                acc_next = d; flags_next = nz(flags, d);
              end
              c6502_pkg::OP_LDXA: begin xr_next = d; flags_next = nz(flags, d); end
              c6502_pkg::OP_ASLM, c6502_pkg::OP_ROLM, c6502_pkg::OP_INCM: begin
                alu_a = d;
                alu_func = (op == c6502_pkg::OP_ASLM) ? 2'd2 : 2'd3;
                m = (op == c6502_pkg::OP_INCM) ? d + 8'd1 : alu_res;
                flags_next = (op == c6502_pkg::OP_INCM) ? nz(flags, m) : alu_flags;
                phase_next = c6502_pkg::PH_WRITE_LAST;
                res.addr = eff; res.wr = 1'b1; res.data = m; res.fetch = 1'b0;
              end
              default: ;
            endcase
          end
          c6502_pkg::PH_JSR_HI: begin
            sp_next = sp - 8'd1; phase_next = c6502_pkg::PH_WRITE_LAST;
            res.addr = {c6502_pkg::STACK_PAGE, sp}; res.wr = 1'b1; res.data = latch;
            res.fetch = 1'b0;
          end
          c6502_pkg::PH_RTS_LO: begin
            latch_next = d; sp_next = sp + 8'd1; phase_next = c6502_pkg::PH_RTS_HI;
            res.addr = {c6502_pkg::STACK_PAGE, sp_next}; res.fetch = 1'b0;
          end
          c6502_pkg::PH_RTS_HI: begin
            pc_next = {d, latch} + 16'd1; res.addr = pc_next;
          end
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= c6502_pkg::START_ADDRESS_RESET;
      sp <= c6502_pkg::STACK_POINTER_RESET;
      acc <= 8'd0; xr <= 8'd0; yr <= 8'd0; latch <= 8'd0;
      flags <= '0; ibytes <= 24'd0; phase <= c6502_pkg::PH_FETCH; halt <= 1'b0;
      out_valid <= 1'b0; skid_valid <= 1'b0;
    end else begin
      if (accept) begin
        pc <= pc_next; sp <= sp_next; acc <= acc_next; xr <= xr_next; yr <= yr_next;
        latch <= latch_next; flags <= flags_next; ibytes <= ibytes_next;
        phase <= phase_next; halt <= halt_next;
      end
      // configuration must only arrive while idle; the core itself does not enforce this
      if (cfg_write) begin
        if (cfg_index == c6502_pkg::CFG_START_ADDRESS) pc <= cfg_data;
        else sp <= cfg_data[7:0];
      end
      // output register with skid
      if (!out_valid || !out_stall) begin
        if (skid_valid) begin
          out_reg <= skid; out_valid <= 1'b1; skid_valid <= 1'b0;
        end else begin
          out_valid <= accept;
          if (accept) out_reg <= res;
        end
      end else if (accept) begin
        skid <= res; skid_valid <= 1'b1;
      end
    end
  end

  assign bus_address = out_reg.addr;
  assign bus_write = out_reg.wr;
  assign write_data = out_reg.data;
  assign is_opcode_fetch = out_reg.fetch;
  assign halted = out_reg.halt;

endmodule

/* src/c6502_checker.sv */
// checker: port-level properties of the 6502 subset core
module c6502_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [15:0] bus_address,
  input logic        bus_write,
  input logic [7:0]  write_data,
  input logic        is_opcode_fetch,
  input logic        halted
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bus_address))
    else $error("stalled result changed");
  a_rdzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !bus_write |-> write_data == 8'd0)
    else $error("read carries write data");
  a_halt: assert property (@(posedge clk) disable iff (rst)
    out_valid && halted |-> !bus_write && !is_opcode_fetch)
    else $error("halted core issued a write or fetch");
  a_fetch: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_opcode_fetch |-> !bus_write)
    else $error("opcode fetch marked as write");
  a_flow: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> !in_stall)
    else $error("input stalled with empty output");
endmodule

bind cpu_6502_subset_core c6502_checker u_checker (.*);

/* test/tb_cpu_6502_subset_core.sv */
// testbench for the 6502 subset core: bus access prediction and checking
`timescale 1ns / 1ps

module tb_cpu_6502_subset_core;

  // one bus access as the core announces it
  typedef struct packed {
    logic [15:0] addr;
    logic        wr;
    logic [7:0]  wdata;
    logic        fetch;
    logic        halt;
  } bus_access_t;

  // predicts the next bus access after each item and checks the core against it
  class bus_access_scoreboard;
    logic [15:0] start_addr, pc;
    logic [7:0]  sp_init, acc, ix, iy, sp, latch;
    c6502_pkg::flags_t fl;
    logic [23:0] ibytes;
    logic [3:0]  phase;
    logic        halt;
    bus_access_t access_q[$];
    bit          next_is_fetch;
    int          errors;

    function new();
      start_addr = c6502_pkg::START_ADDRESS_RESET;
      sp_init = c6502_pkg::STACK_POINTER_RESET;
      pc = start_addr;
      sp = sp_init;
      acc = 8'h00; ix = 8'h00; iy = 8'h00; latch = 8'h00;
      fl = '0; ibytes = 24'h000000; phase = c6502_pkg::PH_FETCH; halt = 1'b0;
      next_is_fetch = 1'b1;
      errors = 0;
    endfunction

    function void write_config(logic [0:0] idx, logic [15:0] data);
      if (idx == c6502_pkg::CFG_START_ADDRESS) begin
        start_addr = data;
        pc = data;
      end else begin
        sp_init = data[7:0];
        sp = data[7:0];
      end
    endfunction

    function void announce(logic [15:0] addr, logic wr, logic [7:0] data, logic fetch);
      bus_access_t e;
      e.addr = addr;
      e.wr = wr;
      e.wdata = wr ? data : 8'h00;
      e.fetch = fetch;
      e.halt = halt;
      access_q.push_back(e);
      next_is_fetch = fetch;
    endfunction

    function void set_nz(logic [7:0] v);
      fl.n = v[7];
      fl.z = (v == 8'h00);
    endfunction

    function void add_with_carry(logic [7:0] m);
      logic [8:0] s;
      s = {1'b0, acc} + {1'b0, m} + {8'h00, fl.c};
      fl.v = ~(acc[7] ^ m[7]) & (acc[7] ^ s[7]);
      fl.c = s[8];
      acc = s[7:0];
      set_nz(acc);
    endfunction

    function void compare(logic [7:0] r, logic [7:0] m);
      logic [7:0] diff;
      diff = r - m;
      fl.c = (r >= m);
      set_nz(diff);
    endfunction

    function void branch(logic taken);
      if (taken) pc = pc + {{8{ibytes[15]}}, ibytes[15:8]};
    endfunction

    function logic [15:0] operand_addr();
      logic [15:0] a;
      a = ibytes[23:8];
      if (ibytes[7:0] == c6502_pkg::OP_LDAX || ibytes[7:0] == c6502_pkg::OP_STAX)
        a = a + {8'h00, ix};
      return a;
    endfunction

    function void write_last(logic [15:0] addr, logic [7:0] data);
      phase = c6502_pkg::PH_WRITE_LAST;
      announce(addr, 1'b1, data, 1'b0);
    endfunction

    function void fetch_next();
      phase = c6502_pkg::PH_FETCH;
      announce(pc, 1'b0, 8'h00, 1'b1);
    endfunction

    function void execute();
      logic [7:0]  b1;
      logic [15:0] ret;
      logic [15:0] stack_addr;
      logic        cin;
      b1 = ibytes[15:8];
      case (ibytes[7:0])
        c6502_pkg::OP_BRK: begin
          halt = 1'b1;
          announce(pc, 1'b0, 8'h00, 1'b0);
          return;
        end
        c6502_pkg::OP_CLC: fl.c = 1'b0;
        c6502_pkg::OP_DEX: begin ix = ix - 8'd1; set_nz(ix); end
        c6502_pkg::OP_DEY: begin iy = iy - 8'd1; set_nz(iy); end
        c6502_pkg::OP_INX: begin ix = ix + 8'd1; set_nz(ix); end
        c6502_pkg::OP_INY: begin iy = iy + 8'd1; set_nz(iy); end
        c6502_pkg::OP_TAX: begin ix = acc; set_nz(ix); end
        c6502_pkg::OP_TAY: begin iy = acc; set_nz(iy); end
        c6502_pkg::OP_TXA: begin acc = ix; set_nz(acc); end
        c6502_pkg::OP_TYA: begin acc = iy; set_nz(acc); end
        c6502_pkg::OP_ASLA: begin
          fl.c = acc[7]; acc = {acc[6:0], 1'b0}; set_nz(acc);
        end
        c6502_pkg::OP_ROLA: begin
          cin = fl.c;
          fl.c = acc[7];
          acc = {acc[6:0], cin};
          set_nz(acc);
        end
        c6502_pkg::OP_ADCI: add_with_carry(b1);
        c6502_pkg::OP_ANDI: begin acc = acc & b1; set_nz(acc); end
        c6502_pkg::OP_EORI: begin acc = acc ^ b1; set_nz(acc); end
        c6502_pkg::OP_CMPI: compare(acc, b1);
        c6502_pkg::OP_CPXI: compare(ix, b1);
        c6502_pkg::OP_CPYI: compare(iy, b1);
        c6502_pkg::OP_LDAI: begin acc = b1; set_nz(acc); end
        c6502_pkg::OP_LDXI: begin ix = b1; set_nz(ix); end
        c6502_pkg::OP_LDYI: begin iy = b1; set_nz(iy); end
        c6502_pkg::OP_BCC: branch(!fl.c);
        c6502_pkg::OP_BCS: branch(fl.c);
        c6502_pkg::OP_BEQ: branch(fl.z);
        c6502_pkg::OP_BNE: branch(!fl.z);
        c6502_pkg::OP_JMP: pc = ibytes[23:8];
        c6502_pkg::OP_ADCA, c6502_pkg::OP_LDAA, c6502_pkg::OP_LDXA, c6502_pkg::OP_LDAX,
        c6502_pkg::OP_ASLM, c6502_pkg::OP_ROLM, c6502_pkg::OP_INCM: begin
          phase = c6502_pkg::PH_READ;
          announce(operand_addr(), 1'b0, 8'h00, 1'b0);
          return;
        end
        c6502_pkg::OP_STAA, c6502_pkg::OP_STAX: begin
          write_last(operand_addr(), acc); return;
        end
        c6502_pkg::OP_STXA: begin write_last(operand_addr(), ix); return; end
        c6502_pkg::OP_STYA: begin write_last(operand_addr(), iy); return; end
        c6502_pkg::OP_PHA: begin
          stack_addr = {c6502_pkg::STACK_PAGE, sp};
          sp = sp - 8'd1;
          write_last(stack_addr, acc);
          return;
        end
        c6502_pkg::OP_PLA: begin
          sp = sp + 8'd1;
          phase = c6502_pkg::PH_READ;
          announce({c6502_pkg::STACK_PAGE, sp}, 1'b0, 8'h00, 1'b0);
          return;
        end
        c6502_pkg::OP_JSR: begin
          ret = pc - 16'd1;
          latch = ret[7:0];
          announce({c6502_pkg::STACK_PAGE, sp}, 1'b1, ret[15:8], 1'b0);
          sp = sp - 8'd1;
          pc = ibytes[23:8];
          phase = c6502_pkg::PH_JSR_HI;
          return;
        end
        c6502_pkg::OP_RTS: begin
          sp = sp + 8'd1;
          phase = c6502_pkg::PH_RTS_LO;
          announce({c6502_pkg::STACK_PAGE, sp}, 1'b0, 8'h00, 1'b0);
          return;
        end
        default: ;
      endcase
      fetch_next();
    endfunction

    function void complete_read(logic [7:0] d);
      logic [7:0] m;
      case (ibytes[7:0])
        c6502_pkg::OP_ADCA: add_with_carry(d);
        c6502_pkg::OP_LDAA, c6502_pkg::OP_LDAX, c6502_pkg::OP_PLA: begin
          acc = d; set_nz(d);
        end
        c6502_pkg::OP_LDXA: begin ix = d; set_nz(d); end
        c6502_pkg::OP_ASLM: begin
          fl.c = d[7];
          m = {d[6:0], 1'b0};
          set_nz(m);
          write_last(operand_addr(), m);
          return;
        end
        c6502_pkg::OP_ROLM: begin
          m = {d[6:0], fl.c};
          fl.c = d[7];
          set_nz(m);
          write_last(operand_addr(), m);
          return;
        end
        c6502_pkg::OP_INCM: begin
          m = d + 8'd1;
          set_nz(m);
          write_last(operand_addr(), m);
          return;
        end
        default: ;
      endcase
      fetch_next();
    endfunction

    // an accepted item completes the pending access
    function void note_input(logic [7:0] d);
      logic [1:0] len;
      len = c6502_pkg::op_length(ibytes[7:0]);
      if (halt) begin
        announce(pc, 1'b0, 8'h00, 1'b0);
        return;
      end
      case (phase)
        c6502_pkg::PH_FETCH: begin
          ibytes = {16'h0000, d};
          pc = pc + 16'd1;
          if (c6502_pkg::op_length(d) > 2'd1) begin
            phase = c6502_pkg::PH_BYTE1;
            announce(pc, 1'b0, 8'h00, 1'b0);
          end else execute();
        end
        c6502_pkg::PH_BYTE1: begin
          ibytes[23:8] = {8'h00, d};
          pc = pc + 16'd1;
          if (len > 2'd2) begin
            phase = c6502_pkg::PH_BYTE2;
            announce(pc, 1'b0, 8'h00, 1'b0);
          end else execute();
        end
        c6502_pkg::PH_BYTE2: begin
          ibytes[23:16] = d;
          pc = pc + 16'd1;
          execute();
        end
        c6502_pkg::PH_READ: complete_read(d);
        c6502_pkg::PH_JSR_HI: begin
          sp = sp - 8'd1;
          write_last({c6502_pkg::STACK_PAGE, sp + 8'd1}, latch);
        end
        c6502_pkg::PH_RTS_LO: begin
          latch = d;
          sp = sp + 8'd1;
          phase = c6502_pkg::PH_RTS_HI;
          announce({c6502_pkg::STACK_PAGE, sp}, 1'b0, 8'h00, 1'b0);
        end
        c6502_pkg::PH_RTS_HI: begin
          pc = {d, latch} + 16'd1;
          fetch_next();
        end
        default: fetch_next();
      endcase
    endfunction

    function void check_result(bus_access_t got);
      bus_access_t e;
      if (access_q.size() == 0) begin
        $error("bus access with none predicted: addr %h", got.addr);
        errors++;
        return;
      end
      e = access_q.pop_front();
      if (got.addr !== e.addr) begin
        $error("bus_address: expected %h got %h", e.addr, got.addr); errors++;
      end
      if (got.wr !== e.wr) begin
        $error("bus_write: expected %b got %b", e.wr, got.wr); errors++;
      end
      if (got.wdata !== e.wdata) begin
        $error("write_data: expected %h got %h", e.wdata, got.wdata); errors++;
      end
      if (got.fetch !== e.fetch) begin
        $error("is_opcode_fetch: expected %b got %b", e.fetch, got.fetch); errors++;
      end
      if (got.halt !== e.halt) begin
        $error("halted: expected %b got %b", e.halt, got.halt); errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_stall;
  logic [7:0]  read_data;
  logic        out_valid;
  logic        out_stall;
  logic [15:0] bus_address;
  logic        bus_write;
  logic [7:0]  write_data;
  logic        is_opcode_fetch;
  logic        halted;
  logic        cfg_write;
  logic [0:0]  cfg_index;
  logic [15:0] cfg_data;

  bus_access_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  int hold_left;
  bit hold_request;

  // every opcode of the subset except brk, which halts for good
  logic [7:0] opcode_pool[] = '{
    c6502_pkg::OP_CLC, c6502_pkg::OP_DEX, c6502_pkg::OP_DEY, c6502_pkg::OP_INX,
    c6502_pkg::OP_INY, c6502_pkg::OP_PLA, c6502_pkg::OP_PHA, c6502_pkg::OP_RTS,
    c6502_pkg::OP_TAX, c6502_pkg::OP_TAY, c6502_pkg::OP_TXA, c6502_pkg::OP_TYA,
    c6502_pkg::OP_ASLA, c6502_pkg::OP_ROLA, c6502_pkg::OP_ADCI, c6502_pkg::OP_ANDI,
    c6502_pkg::OP_CMPI, c6502_pkg::OP_CPXI, c6502_pkg::OP_CPYI, c6502_pkg::OP_EORI,
    c6502_pkg::OP_LDAI, c6502_pkg::OP_LDXI, c6502_pkg::OP_LDYI, c6502_pkg::OP_BCC,
    c6502_pkg::OP_BEQ, c6502_pkg::OP_BNE, c6502_pkg::OP_BCS, c6502_pkg::OP_JMP,
    c6502_pkg::OP_JSR, c6502_pkg::OP_ADCA, c6502_pkg::OP_LDAA, c6502_pkg::OP_LDXA,
    c6502_pkg::OP_LDAX, c6502_pkg::OP_ASLM, c6502_pkg::OP_ROLM, c6502_pkg::OP_INCM,
    c6502_pkg::OP_STAA, c6502_pkg::OP_STAX, c6502_pkg::OP_STXA, c6502_pkg::OP_STYA};

  // directed program: overflow and carry on adc, rol of memory, jsr and rts
  // through the stack, an unknown opcode and an indexed load that wraps
  logic [7:0] directed_bytes[] = '{
    c6502_pkg::OP_LDAI, 8'h7F, c6502_pkg::OP_ADCI, 8'h01, c6502_pkg::OP_ADCI, 8'h80,
    c6502_pkg::OP_ROLM, 8'h34, 8'hFF, 8'hFF, 8'h00,
    c6502_pkg::OP_JSR, 8'h00, 8'h80, 8'h00, 8'h00, c6502_pkg::OP_RTS, 8'h34, 8'h12,
    8'h02, 8'hFF, 8'hFF,
    c6502_pkg::OP_INX, c6502_pkg::OP_LDAX, 8'hFF, 8'hFF, 8'h80};

  cpu_6502_subset_core i_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .read_data(read_data),
    .out_valid(out_valid), .out_stall(out_stall),
    .bus_address(bus_address), .bus_write(bus_write), .write_data(write_data),
    .is_opcode_fetch(is_opcode_fetch), .halted(halted),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #2 clk = ~clk;
  end

  // run limit far above the slowest correct run
  initial begin
    #4ms;
    $display("tb_cpu_6502_subset_core NOT OK");
    $finish;
  end

  // receiver: random stall plus one long hold-off on request
  always @(posedge clk) begin
    if (hold_request) begin
      hold_left = 400;
      hold_request = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else begin
      out_stall <= ($urandom_range(99) < rx_idle_pct);
    end
  end

  // results are sampled before the edge updates them
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      sb.check_result({bus_address, bus_write, write_data, is_opcode_fetch, halted});
  end

  // offer one item, idling first at the sender's rate, note it when taken
  task automatic send_item(logic [7:0] d);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    read_data <= d;
    do @(posedge clk); while (in_stall);
    sb.note_input(d);
  endtask

  // mostly subset opcodes when a fetch is pending (now and then any byte but brk), otherwise any byte
  function automatic logic [7:0] pick_byte();
    logic [7:0] b;
    if (!sb.next_is_fetch) return 8'($urandom);
    if ($urandom_range(15) == 0) begin
      b = 8'($urandom);
      return (b == c6502_pkg::OP_BRK) ? 8'hEA : b;
    end
    return opcode_pool[$urandom_range(opcode_pool.size() - 1)];
  endfunction

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.access_q.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_register(logic [0:0] idx, logic [15:0] data);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    sb.write_config(idx, data);
    cfg_write <= 1'b0;
  endtask

  task automatic random_items(int count);
    repeat (count) send_item(pick_byte());
  endtask

  initial begin
    sb = new();
    hold_left = 0;
    hold_request = 0;
    tx_idle_pct = 20;
    rx_idle_pct = 66;
    rst <= 1'b1;
    in_valid <= 1'b0;
    read_data <= 8'h00;
    out_stall <= 1'b0;
    cfg_write <= 1'b0;
    cfg_index <= c6502_pkg::CFG_START_ADDRESS;
    cfg_data <= 16'h0000;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // reset values of both registers first
    foreach (directed_bytes[i]) send_item(directed_bytes[i]);
    random_items(450);
    drain();

    // lowest start address and a stack pointer of zero that wraps on the first push
    write_register(c6502_pkg::CFG_START_ADDRESS, 16'h0000);
    write_register(c6502_pkg::CFG_STACK_POINTER, 16'h0000);
    tx_idle_pct = 66;
    rx_idle_pct = 20;
    random_items(480);
    drain();

    // highest start address, so the counter wraps on the first fetch
    write_register(c6502_pkg::CFG_START_ADDRESS, 16'hFFFF);
    write_register(c6502_pkg::CFG_STACK_POINTER, 16'h00FF);
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    random_items(20);
    hold_request = 1;
    random_items(460);

    // brk at the next opcode fetch, then a few items that must see a halted core
    while (!sb.next_is_fetch) send_item(pick_byte());
    send_item(c6502_pkg::OP_BRK);
    random_items(8);
    drain();
    repeat (20) @(posedge clk);

    if (sb.errors == 0 && sb.access_q.size() == 0) begin
      $display("tb_cpu_6502_subset_core OK");
    end else begin
      $display("tb_cpu_6502_subset_core NOT OK");
    end
    $finish;
  end

endmodule

/* sim.f */
src/c6502_pkg.sv
src/c6502_alu.sv
src/cpu_6502_subset_core.sv
src/c6502_checker.sv
test/tb_cpu_6502_subset_core.sv
